// ===== hdl/pbr_pkg.sv =====
// Shared types and constants for the page buffer replacement block.
package pbr_pkg;

  localparam logic [1:0] POL_LRU   = 2'd0;
  localparam logic [1:0] POL_FIFO  = 2'd1;
  localparam logic [1:0] POL_CLOCK = 2'd2;
  localparam logic [1:0] POL_MRU   = 2'd3;

  typedef struct packed {
    logic [15:0] page_id;
    logic        dirty_in;
    logic        backing_found;
  } pbr_in_t;

  typedef struct packed {
    logic        hit;
    logic        not_found;
    logic        evicted;
    logic [15:0] evicted_page;
    logic        evicted_dirty;
    logic [31:0] hit_count;
    logic [31:0] miss_count;
  } pbr_out_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture request and run the slot search
    logic hit_upd;   // apply hit bookkeeping
    logic miss_cnt;  // bump miss counter
    logic pick;      // resolve non-clock victim
    logic sweep;     // one clock-hand step
    logic remove;    // evict victim and compact
    logic append;    // insert new page
    logic emit;      // drive result strobe
  } pbr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hit;
    logic found;
    logic full;
    logic is_clock;
    logic sweep_done;
  } pbr_sts_t;

endpackage

// ===== hdl/pbr_datapath.sv =====
// Slot store, search, victim selection, compaction and counters.
module pbr_datapath #(
  parameter int SLOTS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        policy,
  input  pbr_pkg::pbr_in_t  req,
  input  pbr_pkg::pbr_cmd_t cmd,
  output pbr_pkg::pbr_sts_t sts,
  output logic              out_valid,
  output pbr_pkg::pbr_out_t out_data
);
  import pbr_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int FW = $clog2(SLOTS + 1);
  localparam logic [FW-1:0] FULL = FW'(SLOTS);

  logic [15:0]   page_r [SLOTS];
  logic          dirty_r [SLOTS];
  logic [SLOTS-1:0] ref_r, ref_nxt;
  logic [IW-1:0] rec_r [SLOTS];
  logic [IW-1:0] arr_r [SLOTS];
  logic [15:0]   page_nxt [SLOTS];
  logic          dirty_nxt [SLOTS];
  logic [IW-1:0] rec_nxt [SLOTS];
  logic [IW-1:0] arr_nxt [SLOTS];
  logic [FW-1:0] fill_r, fill_nxt;
  logic [IW-1:0] hand_r, hand_nxt;
  logic [31:0]   hits_r, hits_nxt, miss_r, miss_nxt;
  pbr_in_t       req_r;
  logic          hit_r, found_r;
  logic [IW-1:0] idx_r, vic_r, vic_nxt;
  logic          sdone_r, sdone_nxt;
  logic          ovalid_r;
  pbr_out_t      out_r, out_nxt;

  // parallel search
  logic          m_hit;
  logic [IW-1:0] m_idx;
  always_comb begin
    m_hit = 1'b0;
    m_idx = '0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (FW'(k) < fill_r && page_r[k] == req.page_id) begin
        m_hit = 1'b1;
        m_idx = IW'(k);
      end
    end
  end

  // rank lookup for LRU / MRU / FIFO
  logic [IW-1:0] want, pick_idx;
  always_comb begin
    priority case (policy)
      POL_LRU:  want = IW'(fill_r - FW'(1));
      POL_FIFO: want = '0;
      default:  want = '0;
    endcase
    pick_idx = '0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (FW'(k) < fill_r &&
          (policy == POL_FIFO ? arr_r[k] : rec_r[k]) == want)
        pick_idx = IW'(k);
    end
  end

  logic [IW-1:0] hand_inc;
  assign hand_inc = (hand_r == IW'(SLOTS - 1)) ? '0 : hand_r + IW'(1);

  assign sts.hit        = hit_r;
  assign sts.found      = found_r;
  assign sts.full       = (fill_r == FULL);
  assign sts.is_clock   = (policy == POL_CLOCK);
  assign sts.sweep_done = sdone_r;

  always_comb begin
    page_nxt  = page_r;
    dirty_nxt = dirty_r;
    rec_nxt   = rec_r;
    arr_nxt   = arr_r;
    ref_nxt   = ref_r;
    fill_nxt  = fill_r;
    hand_nxt  = hand_r;
    hits_nxt  = hits_r;
    miss_nxt  = miss_r;
    vic_nxt   = vic_r;
    sdone_nxt = sdone_r;
    out_nxt   = out_r;
    if (cmd.load) begin
      sdone_nxt = 1'b0;
      out_nxt   = '0;
    end
    if (cmd.hit_upd) begin
      hits_nxt = hits_r + 32'd1;
      for (int k = 0; k < SLOTS; k++)
        if (FW'(k) < fill_r && rec_r[k] < rec_r[idx_r]) rec_nxt[k] = rec_r[k] + IW'(1);
      rec_nxt[idx_r] = '0;
      if (policy == POL_CLOCK) ref_nxt[idx_r] = 1'b1;
      out_nxt.hit = 1'b1;
    end
    if (cmd.miss_cnt) begin
      miss_nxt = miss_r + 32'd1;
      out_nxt.not_found = ~found_r;
    end
    if (cmd.pick) begin
      vic_nxt   = pick_idx;
      sdone_nxt = 1'b1;
    end
    if (cmd.sweep) begin
      hand_nxt = hand_inc;
      if (!ref_r[hand_r]) begin
        vic_nxt   = hand_r;
        sdone_nxt = 1'b1;
      end else begin
        ref_nxt[hand_r] = 1'b0;
      end
    end
    if (cmd.remove) begin
      out_nxt.evicted       = 1'b1;
      out_nxt.evicted_page  = page_r[vic_r];
      out_nxt.evicted_dirty = dirty_r[vic_r];
      if (policy == POL_CLOCK) begin
        if (hand_r > vic_r) hand_nxt = hand_r - IW'(1);
        else if (FW'(hand_r) == fill_r - FW'(1)) hand_nxt = '0;
      end
      for (int k = 0; k < SLOTS; k++) begin
        if (rec_r[k] > rec_r[vic_r]) rec_nxt[k] = rec_r[k] - IW'(1);
        if (arr_r[k] > arr_r[vic_r]) arr_nxt[k] = arr_r[k] - IW'(1);
      end
      for (int k = 0; k < SLOTS - 1; k++) begin
        if (IW'(k) >= vic_r) begin
          page_nxt[k]  = page_r[k+1];
          dirty_nxt[k] = dirty_r[k+1];
          ref_nxt[k]   = ref_r[k+1];
          rec_nxt[k]   = (rec_r[k+1] > rec_r[vic_r]) ? rec_r[k+1] - IW'(1) : rec_r[k+1];
          arr_nxt[k]   = (arr_r[k+1] > arr_r[vic_r]) ? arr_r[k+1] - IW'(1) : arr_r[k+1];
        end
      end
      ref_nxt[SLOTS-1] = 1'b0;
      fill_nxt = fill_r - FW'(1);
    end
    if (cmd.append) begin
      for (int k = 0; k < SLOTS; k++)
        if (FW'(k) < fill_r) rec_nxt[k] = rec_r[k] + IW'(1);
      page_nxt[IW'(fill_r)]  = req_r.page_id;
      dirty_nxt[IW'(fill_r)] = req_r.dirty_in;
      ref_nxt[IW'(fill_r)]   = 1'b1;
      rec_nxt[IW'(fill_r)]   = '0;
      arr_nxt[IW'(fill_r)]   = IW'(fill_r);
      fill_nxt = fill_r + FW'(1);
    end
    out_nxt.hit_count  = hits_nxt;
    out_nxt.miss_count = miss_nxt;
  end

  always_ff @(posedge clk) begin
    page_r  <= page_nxt;
    dirty_r <= dirty_nxt;
    rec_r   <= rec_nxt;
    arr_r   <= arr_nxt;
    vic_r   <= vic_nxt;
    out_r   <= out_nxt;
    if (cmd.load) begin
      req_r   <= req;
      hit_r   <= m_hit;
      idx_r   <= m_idx;
      found_r <= req.backing_found;
    end
    if (!rst_n) begin
      ref_r    <= '0;
      fill_r   <= '0;
      hand_r   <= '0;
      hits_r   <= '0;
      miss_r   <= '0;
      sdone_r  <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      ref_r    <= ref_nxt;
      fill_r   <= fill_nxt;
      hand_r   <= hand_nxt;
      hits_r   <= hits_nxt;
      miss_r   <= miss_nxt;
      sdone_r  <= sdone_nxt;
      ovalid_r <= cmd.emit;
    end
  end

  assign out_valid = ovalid_r;
  assign out_data  = out_r;

endmodule

// ===== hdl/pbr_ctrl.sv =====
// Request sequencer for the page buffer replacement block.
module pbr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  pbr_pkg::pbr_sts_t sts,
  output pbr_pkg::pbr_cmd_t cmd
);
  import pbr_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECIDE = 6'b000010,
    S_VICTIM = 6'b000100,
    S_REMOVE = 6'b001000,
    S_APPEND = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.hit) begin
          cmd.hit_upd = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.miss_cnt = 1'b1;
          if (!sts.found) state_nxt = S_DONE;
          else if (sts.full) state_nxt = S_VICTIM;
          else state_nxt = S_APPEND;
        end
      end
      S_VICTIM: begin
        // clock sweep takes one slot per cycle
        if (sts.sweep_done) state_nxt = S_REMOVE;
        else if (sts.is_clock) cmd.sweep = 1'b1;
        else cmd.pick = 1'b1;
      end
      S_REMOVE: begin
        cmd.remove = 1'b1;
        state_nxt  = S_APPEND;
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// ===== hdl/page_buffer_replacement.sv =====
// Page buffer replacement: one request at a time. After start is taken, a hit or an
// absent page goes straight to the result; a miss with insert appends the page first;
// with eviction it picks a victim (LRU/FIFO/MRU) or sweeps one slot per cycle (CLOCK),
// then removes the victim and appends. busy drops in the cycle of the result strobe.
// out_valid lasts one cycle and cannot be stalled; capture it then.
module page_buffer_replacement #(
  parameter int SLOTS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  pbr_pkg::pbr_in_t in_data,
  output logic             out_valid,
  output pbr_pkg::pbr_out_t out_data,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_data
);
  import pbr_pkg::*;

  logic [1:0] policy_r;
  pbr_cmd_t   cmd;
  pbr_sts_t   sts;

  always_ff @(posedge clk) begin
    if (!rst_n) policy_r <= POL_LRU;
    else if (cfg_we) policy_r <= cfg_data;
  end

  pbr_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
  );

  pbr_datapath #(.SLOTS(SLOTS)) u_dp (
    .clk(clk), .rst_n(rst_n), .policy(policy_r), .req(in_data), .cmd(cmd),
    .sts(sts), .out_valid(out_valid), .out_data(out_data)
  );

endmodule

// ===== hdl/pbr_checker.sv =====
// Port-level checks for the page buffer replacement block.
module pbr_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input pbr_pkg::pbr_out_t out_data
);
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accept did not raise busy");
  a_strobe_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("strobe longer than one cycle");
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.hit && (out_data.not_found || out_data.evicted)))
    else $error("hit with miss flags");
  a_noev: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.evicted |-> out_data.evicted_page == 16'd0)
    else $error("evicted page without eviction");
endmodule

bind page_buffer_replacement pbr_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_data(out_data)
);

// ===== tb/sv/tb_page_buffer_replacement.sv =====
// Testbench for page_buffer_replacement: random and directed page requests checked by a scoreboard.
module tb_page_buffer_replacement;
  timeunit 1ns;
  timeprecision 1ps;
  import pbr_pkg::*;

  localparam int SLOTS = 8;
  localparam int WATCHDOG_LIMIT = 2000;

  class pbr_scoreboard;
    logic [15:0] pg [SLOTS];
    logic        dty [SLOTS];
    logic        rbit [SLOTS];
    int          rec [SLOTS];
    int          arr [SLOTS];
    int          fill;
    int          hand;
    logic [31:0] hits;
    logic [31:0] misses;
    logic [1:0]  policy;
    pbr_out_t    pending_results[$];
    int          errors;

    function new();
      fill = 0; hand = 0; hits = '0; misses = '0; policy = POL_LRU; errors = 0;
      for (int k = 0; k < SLOTS; k++) begin
        rbit[k] = 1'b0; rec[k] = 0; arr[k] = 0; pg[k] = '0; dty[k] = 1'b0;
      end
    endfunction

    function int rank_slot(bit by_arrival, int want);
      for (int k = 0; k < fill; k++)
        if ((by_arrival ? arr[k] : rec[k]) == want) return k;
      return 0;
    endfunction

    function int choose_victim();
      int h;
      case (policy)
        POL_LRU:  return rank_slot(0, fill - 1);
        POL_MRU:  return rank_slot(0, 0);
        POL_FIFO: return rank_slot(1, 0);
        default: begin
          for (int g = 0; g <= 2 * SLOTS; g++) begin
            h = hand % SLOTS;
            hand = (h + 1) % SLOTS;
            if (!rbit[h]) return h;
            rbit[h] = 1'b0;
          end
          return 0;
        end
      endcase
    endfunction

    function void drop_slot(int v);
      int rr, ar;
      rr = rec[v]; ar = arr[v];
      for (int k = 0; k < fill; k++) begin
        if (rec[k] > rr) rec[k]--;
        if (arr[k] > ar) arr[k]--;
      end
      for (int k = v; k + 1 < fill; k++) begin
        pg[k] = pg[k+1]; dty[k] = dty[k+1]; rbit[k] = rbit[k+1];
        rec[k] = rec[k+1]; arr[k] = arr[k+1];
      end
      fill--;
      rbit[fill] = 1'b0;
    endfunction

    function void note_request(pbr_in_t req);
      pbr_out_t r;
      int idx, v, rr;
      r = '0;
      idx = -1;
      for (int k = 0; k < fill; k++)
        if (idx < 0 && pg[k] == req.page_id) idx = k;
      if (idx >= 0) begin
        r.hit = 1'b1;
        hits++;
        rr = rec[idx];
        for (int k = 0; k < fill; k++) if (rec[k] < rr) rec[k]++;
        rec[idx] = 0;
        if (policy == POL_CLOCK) rbit[idx] = 1'b1;
      end else begin
        misses++;
        if (!req.backing_found) r.not_found = 1'b1;
        else begin
          if (fill >= SLOTS) begin
            v = choose_victim();
            r.evicted = 1'b1;
            r.evicted_page = pg[v];
            r.evicted_dirty = dty[v];
            if (policy == POL_CLOCK) begin
              if (hand > v) hand--;
              else if (hand == fill - 1) hand = 0;
            end
            drop_slot(v);
          end
          for (int k = 0; k < fill; k++) rec[k]++;
          pg[fill] = req.page_id; dty[fill] = req.dirty_in; rbit[fill] = 1'b1;
          rec[fill] = 0; arr[fill] = fill;
          fill++;
        end
      end
      r.hit_count = hits;
      r.miss_count = misses;
      pending_results.insert(pending_results.size(), r);
    endfunction

    function void check_result(pbr_out_t got);
      pbr_out_t e;
      if (pending_results.size() == 0) begin
        $error("result with no transaction outstanding");
        errors++;
        return;
      end
      e = pending_results.pop_front();
      if (got.hit !== e.hit) begin
        $error("hit exp %0d got %0d", e.hit, got.hit); errors++;
      end
      if (got.not_found !== e.not_found) begin
        $error("not_found exp %0d got %0d", e.not_found, got.not_found); errors++;
      end
      if (got.evicted !== e.evicted) begin
        $error("evicted exp %0d got %0d", e.evicted, got.evicted); errors++;
      end
      if (got.evicted_page !== e.evicted_page) begin
        $error("evicted_page exp %0h got %0h", e.evicted_page, got.evicted_page); errors++;
      end
      if (got.evicted_dirty !== e.evicted_dirty) begin
        $error("evicted_dirty exp %0d got %0d", e.evicted_dirty, got.evicted_dirty); errors++;
      end
      if (got.hit_count !== e.hit_count) begin
        $error("hit_count exp %0d got %0d", e.hit_count, got.hit_count); errors++;
      end
      if (got.miss_count !== e.miss_count) begin
        $error("miss_count exp %0d got %0d", e.miss_count, got.miss_count); errors++;
      end
    endfunction
  endclass

  logic      clk = 0;
  logic      rst_n = 0;
  logic      start = 0;
  logic      busy;
  pbr_in_t   in_data = '0;
  logic      out_valid;
  pbr_out_t  out_data;
  logic      cfg_we = 0;
  logic [1:0] cfg_data = '0;
  int        idle_cycles = 0;

  pbr_scoreboard sb = new();

  page_buffer_replacement #(.SLOTS(SLOTS)) u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // results checked on the edge that ends the strobe cycle
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic idle_gap();
    int n;
    if ($urandom_range(0, 3) == 0) n = 0;
    else if ($urandom_range(0, 15) == 0) n = $urandom_range(10, 40);
    else n = $urandom_range(0, 3);
    repeat (n) @(posedge clk);
  endtask

  task automatic send_request(logic [15:0] page, logic d, logic bf);
    pbr_in_t req;
    req.page_id = page; req.dirty_in = d; req.backing_found = bf;
    start <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (busy);
    sb.note_request(req);
    start <= 1'b0;
    // busy is still high here, so this costs no throughput
    @(posedge clk);
    idle_gap();
  endtask

  task automatic drain();
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_policy(logic [1:0] p);
    cfg_we <= 1;
    cfg_data <= p;
    @(posedge clk);
    cfg_we <= 0;
    sb.policy = p;
  endtask

  // pages from a small pool so hits and evictions are frequent
  task automatic random_phase(int count, int pool);
    logic [15:0] page;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) page = 16'($urandom());
      else page = 16'(16'h5A00 + $urandom_range(0, pool - 1));
      if ($urandom_range(0, 1)) page = page ^ 16'hA5FF;
      send_request(page, 1'($urandom_range(0, 1)), $urandom_range(0, 7) != 0);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes, absent page, fill then evict, hit on full buffer
    send_request(16'h0000, 1'b1, 1'b1);
    send_request(16'hFFFF, 1'b0, 1'b1);
    send_request(16'h1234, 1'b1, 1'b0);
    send_request(16'h0000, 1'b0, 1'b1);
    for (int k = 0; k < 7; k++) send_request(16'(16'h0100 + k), k[0], 1'b1);
    send_request(16'hFFFF, 1'b1, 1'b1);
    send_request(16'hFFFF, 1'b1, 1'b0);
    drain();
    set_policy(POL_CLOCK);
    send_request(16'h0101, 1'b0, 1'b1);
    send_request(16'h7777, 1'b1, 1'b1);
    send_request(16'h8888, 1'b0, 1'b1);
    drain();
    set_policy(POL_MRU);
    send_request(16'h9999, 1'b1, 1'b1);
    send_request(16'h8888, 1'b0, 1'b1);
    drain();
    set_policy(POL_FIFO);
    send_request(16'hAAAA, 1'b1, 1'b1);
    send_request(16'hBBBB, 1'b0, 1'b1);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      set_policy(ph == 7 ? POL_CLOCK : 2'($urandom_range(0, 3)));
      random_phase(60, ph[0] ? 10 : 14);
      drain();
    end

    if (sb.errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule
